>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the LRU tag store.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SALRU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define SALRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/salru_pkg.sv
// Package of the LRU tag store: word types, control structs, constants.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package salru_pkg;

   localparam int DEF_SETS = 256;
   localparam int DEF_WAYS = 8;
   localparam int TAG_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Access kind carried in req_type.
   localparam logic ACC_WRITE = 1'b1;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [1:0] REG_SET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

   localparam logic [2:0] RST_OFFSET_BITS = 3'd5;
   localparam logic [3:0] RST_SET_BITS = 4'd8;
   localparam logic [3:0] RST_WAYS_IN_USE = 4'd4;

   typedef struct packed {
      logic        req_type;
      logic [31:0] address;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  way;
      logic [7:0]  set_sel;
      logic        victim_valid;
      logic        victim_dirty;
      logic [31:0] victim_tag;
   } rsp_word_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic commit;
   } salru_cmd_type;

   typedef struct packed {
      logic clear_last;
   } salru_status_type;

endpackage

>>> sv/salru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the set rows of the LRU tag store.
`timescale 1ns / 1ps

module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/salru_ctrl.sv
// Controller of the LRU tag store: clearing pass, lookup and commit sequencing.
// Depends on salru_pkg; drives the datapath through salru_cmd_type.
`timescale 1ns / 1ps

module salru_ctrl import salru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  salru_status_type status,
   output salru_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The set row is in the read register; write it back once the
            // result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/salru_dpath.sv
// Datapath of the LRU tag store: address split, set RAM, way compare,
// victim choice, rank update and result register.
// Depends on salru_pkg and salru_ram.
`timescale 1ns / 1ps

module salru_dpath import salru_pkg::*; #(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic             clock,
   input  logic             reset,
   input  salru_cmd_type    cmd,
   output salru_status_type status,
   input  req_word_type     req_word,
   input  logic [2:0]       offset_bits,
   input  logic [3:0]       set_bits,
   input  logic [3:0]       ways_in_use,
   output rsp_word_type     rsp_word
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NW_W = $clog2(WAYS + 1);
   localparam int MAX_SB = $clog2(SETS + 1) - 1;
   localparam int ENTRY_W = TAG_W + 2 + WAY_W;
   localparam int ROW_W = WAYS * ENTRY_W;
   localparam logic [3:0] MAX_SB_4 = 4'(MAX_SB);
   localparam logic [4:0] WAYS_5 = 5'(WAYS);
   localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(WAYS - 1);
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

   // Address split of the incoming word.
   logic [3:0]       sb;
   logic [31:0]      addr_shifted;
   logic [SET_W:0]   set_mask;
   logic [SET_W-1:0] set_idx;
   logic [TAG_W-1:0] tag_val;
   logic [4:0]       nways_5;

   always_comb begin
      sb           = (set_bits > MAX_SB_4) ? MAX_SB_4 : set_bits;
      addr_shifted = req_word.address >> offset_bits;
      set_mask     = ((SET_W + 1)'(1) << sb) - (SET_W + 1)'(1);
      set_idx      = SET_W'(addr_shifted) & set_mask[SET_W-1:0];
      tag_val      = req_word.address >> (5'(offset_bits) + 5'(sb));
      if (ways_in_use == 4'd0) begin
         nways_5 = 5'd1;
      end else if ({1'b0, ways_in_use} > WAYS_5) begin
         nways_5 = WAYS_5;
      end else begin
         nways_5 = {1'b0, ways_in_use};
      end
   end

   logic             is_write_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic [NW_W-1:0]  nways_ff;
   logic [SET_W-1:0] clr_ff;
   rsp_word_type     rsp_word_ff;
   rsp_word_type     rsp_word_in;

   // Set RAM: one row holds valid, dirty, tag and rank of every way.
   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] upd_row;
   logic [ROW_W-1:0] clear_row;

   salru_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SETS)
   ) u_set_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.capture),
      .rd_addr(set_idx),
      .rd_data(rd_row)
   );

   logic [WAYS-1:0]  v_rd;
   logic [WAYS-1:0]  d_rd;
   logic [TAG_W-1:0] t_rd [WAYS];
   logic [WAY_W-1:0] r_rd [WAYS];
   logic [WAYS-1:0]  in_use;
   logic [WAYS-1:0]  match;
   logic [WAYS-1:0]  free;
   logic [WAYS-1:0]  oldest;
   logic             hit_any;
   logic             free_any;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] lru_way;
   logic [WAY_W-1:0] sel_way;
   logic [WAY_W-1:0] old_rank;
   logic             victim_valid;
   logic             v_n;
   logic             d_n;
   logic [TAG_W-1:0] t_n;
   logic [WAY_W-1:0] r_n;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         v_rd[i]   = rd_row[i*ENTRY_W + ENTRY_W - 1];
         d_rd[i]   = rd_row[i*ENTRY_W + ENTRY_W - 2];
         t_rd[i]   = rd_row[i*ENTRY_W + WAY_W +: TAG_W];
         r_rd[i]   = rd_row[i*ENTRY_W +: WAY_W];
         in_use[i] = int'(nways_ff) > i;
         match[i]  = in_use[i] && v_rd[i] && (t_rd[i] == tag_ff);
         free[i]   = in_use[i] && !v_rd[i];
         clear_row[i*ENTRY_W +: ENTRY_W] = {2'b00, {TAG_W{1'b0}}, WAY_W'(i)};
      end
   end

   // Pairwise rank compare: a way is the LRU candidate if no lower way in use
   // has a rank as high and no higher way in use has a greater rank.
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         oldest[i] = in_use[i];
         for (int j = 0; j < WAYS; j++) begin
            if (j != i && in_use[j]) begin
               if (j < i) begin
                  if (r_rd[i] <= r_rd[j]) begin
                     oldest[i] = 1'b0;
                  end
               end else if (r_rd[i] < r_rd[j]) begin
                  oldest[i] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      lru_way  = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = WAY_W'(i);
         end
         if (free[i]) begin
            free_way = WAY_W'(i);
         end
         if (oldest[i]) begin
            lru_way = WAY_W'(i);
         end
      end
      hit_any  = |match;
      free_any = |free;
      if (hit_any) begin
         sel_way = hit_way;
      end else if (free_any) begin
         sel_way = free_way;
      end else begin
         sel_way = lru_way;
      end
      old_rank     = r_rd[sel_way];
      victim_valid = !hit_any && !free_any;
   end

   // New row: the chosen way becomes most recent, younger ways age by one.
   always_comb begin
      upd_row = rd_row;
      for (int i = 0; i < WAYS; i++) begin
         v_n = v_rd[i];
         d_n = d_rd[i];
         t_n = t_rd[i];
         r_n = r_rd[i];
         if (in_use[i]) begin
            if (WAY_W'(i) == sel_way) begin
               r_n = '0;
               if (hit_any) begin
                  d_n = d_rd[i] || is_write_ff;
               end else begin
                  v_n = 1'b1;
                  d_n = is_write_ff;
                  t_n = tag_ff;
               end
            end else if (r_rd[i] < old_rank && r_rd[i] != RANK_MAX) begin
               r_n = r_rd[i] + 1'b1;
            end
         end
         upd_row[i*ENTRY_W +: ENTRY_W] = {v_n, d_n, t_n, r_n};
      end
   end

   always_comb begin
      rsp_word_in.hit          = hit_any;
      rsp_word_in.way          = 3'(sel_way);
      rsp_word_in.set_sel      = 8'(set_ff);
      rsp_word_in.victim_valid = victim_valid;
      rsp_word_in.victim_dirty = victim_valid && d_rd[sel_way];
      rsp_word_in.victim_tag   = victim_valid ? t_rd[sel_way] : '0;
   end

   assign ram_wr_en   = cmd.clear_step || cmd.commit;
   assign ram_wr_addr = cmd.clear_step ? clr_ff : set_ff;
   assign ram_wr_data = cmd.clear_step ? clear_row : upd_row;

   assign status.clear_last = (clr_ff == SET_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_write_ff <= (req_word.req_type == ACC_WRITE);
         tag_ff      <= tag_val;
         set_ff      <= set_idx;
         nways_ff    <= NW_W'(nways_5);
      end
      if (cmd.commit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

>>> sv/set_assoc_lru_cache_tags.sv
// Set-associative LRU tag store, top level: APB registers, controller, datapath.
// Each accepted word is captured (set RAM read), then committed (row write-back and result load onto rsp);
// a new word is taken only after the commit of the last one, which waits while a result is still held.
// Reset (synchronous): registers to defaults, then a clearing pass writes every set row
// while req_ready is low. Depends on salru_pkg and submodules.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_assoc_lru_cache_tags import salru_pkg::*; #(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration registers. They are to be written only while the block is idle (the
   // block does not enforce it), so the datapath samples them directly when a word is accepted.
   logic [2:0] offset_bits_ff;
   logic [3:0] set_bits_ff;
   logic [3:0] ways_in_use_ff;
   logic [1:0] csr_index;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= RST_OFFSET_BITS;
         set_bits_ff    <= RST_SET_BITS;
         ways_in_use_ff <= RST_WAYS_IN_USE;
      end else if (csr_write) begin
         // A write to an index beyond the register list is dropped.
         unique case (csr_index)
            REG_OFFSET_BITS: offset_bits_ff <= pwdata[2:0];
            REG_SET_BITS:    set_bits_ff    <= pwdata[3:0];
            REG_WAYS_IN_USE: ways_in_use_ff <= pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_OFFSET_BITS: prdata = CSR_DATA_W'(offset_bits_ff);
         REG_SET_BITS:    prdata = CSR_DATA_W'(set_bits_ff);
         REG_WAYS_IN_USE: prdata = CSR_DATA_W'(ways_in_use_ff);
         default:         prdata = '0;
      endcase
   end

   // The controller sequences the clearing pass and, per word, a capture
   // step (set row read) followed by a commit step (row write and result
   // load). The commit waits while an earlier result is still on rsp.
   salru_cmd_type    cmd;
   salru_status_type status;

   salru_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the set RAM, the way compare, the victim choice, the
   // rank update and the result register.
   salru_dpath #(
      .SETS(SETS),
      .WAYS(WAYS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_word   (req_word),
      .offset_bits(offset_bits_ff),
      .set_bits   (set_bits_ff),
      .ways_in_use(ways_in_use_ff),
      .rsp_word   (rsp_word)
   );

   // One word is in flight at a time: after an accept the block is busy.
   `SALRU_ASSERT(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready, "word accepted while previous word in flight")
   // A hit never reports a victim.
   `SALRU_ASSERT(a_hit_no_victim, clock, reset, (rsp_valid && rsp_word.hit) |-> (!rsp_word.victim_valid && !rsp_word.victim_dirty && (rsp_word.victim_tag == '0)), "victim reported on a hit")
   // Without a valid victim the dirty mark and the tag read as zero.
   `SALRU_ASSERT(a_empty_victim, clock, reset, (rsp_valid && !rsp_word.victim_valid) |-> (!rsp_word.victim_dirty && (rsp_word.victim_tag == '0)), "stale victim fields")

endmodule

>>> verif/set_assoc_lru_cache_tags_tb.sv
// Testbench for set_assoc_lru_cache_tags: directed and random access streams, checked
// word by word against a behavioral tag store kept inside the bench. Depends on salru_pkg.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_tb;
   import salru_pkg::*;

   localparam int N_SETS = DEF_SETS;
   localparam int N_WAYS = DEF_WAYS;
   localparam int ENTRIES = N_SETS * N_WAYS;
   // Largest usable set_bits value: log2 of the biggest power of two not above N_SETS.
   localparam int MAX_SET_BITS = $clog2(N_SETS + 1) - 1;
   localparam logic ACC_READ = ~ACC_WRITE;
   // Index past the last register; writes to it must be dropped by the block.
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 300;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 115;

   typedef enum {RX_STREAM, RX_SPARSE, RX_COIN, RX_RHYTHM} rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   set_assoc_lru_cache_tags #(.SETS(N_SETS), .WAYS(N_WAYS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Behavioral copy of the tag store. Entry number is set * N_WAYS + way, and
   // rank 0 marks the most recently used way of a set.
   bit line_valid [ENTRIES];
   bit line_dirty [ENTRIES];
   logic [31:0] line_tag [ENTRIES];
   int unsigned line_rank [ENTRIES];
   int unsigned cfg_offset_bits = 32'(RST_OFFSET_BITS);
   int unsigned cfg_set_bits = 32'(RST_SET_BITS);
   int unsigned cfg_ways = 32'(RST_WAYS_IN_USE);

   // Lookup results still owed by the block, oldest first.
   rsp_word_type pending_lookups[$];
   int unsigned mismatch_count = 0;

   // Sender pacing: bursts of random length separated by random gaps.
   bit pace_on = 1'b1;
   int unsigned burst_left = 8;

   // Receiver control: the pressure test asks for a long hold through hold_request.
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned stall_tick = 0;
   rx_pattern_type stall_mode = RX_STREAM;

   int unsigned idle_cycles = 0;

   // The set_bits register may hold more bits than the built set count allows;
   // the block clamps it when the address is split.
   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
   endfunction

   // A way count of zero behaves as one, and anything above the built count as all ways.
   function automatic int unsigned eff_ways();
      if (cfg_ways == 0)
         return 1;
      if (cfg_ways > N_WAYS)
         return N_WAYS;
      return cfg_ways;
   endfunction

   // Make way w the most recent. Ways that were more recent than w age by one;
   // ways outside the count in use are left alone.
   function automatic void promote_way(int unsigned base, int unsigned nways, int unsigned w);
      int unsigned old_rank;
      old_rank = line_rank[base + w];
      for (int unsigned i = 0; i < nways; i++) begin
         if (i != w && line_rank[base + i] < old_rank && line_rank[base + i] < N_WAYS - 1)
            line_rank[base + i]++;
      end
      line_rank[base + w] = 0;
   endfunction

   // Work out the result of one access and update the stored set to match.
   function automatic rsp_word_type cache_lookup(req_word_type w);
      rsp_word_type r;
      int unsigned sb, nways, set_no, base, pick, best;
      logic [31:0] tag;
      bit found;
      sb = eff_set_bits();
      nways = eff_ways();
      set_no = (w.address >> cfg_offset_bits) & ((32'd1 << sb) - 1);
      tag = w.address >> (cfg_offset_bits + sb);
      base = set_no * N_WAYS;
      r = '0;
      r.set_sel = set_no[7:0];
      found = 1'b0;
      pick = 0;
      // Several ways can hold the same tag after a configuration change; the
      // lowest-numbered one wins.
      for (int unsigned i = 0; i < nways && !found; i++) begin
         if (line_valid[base + i] && line_tag[base + i] == tag) begin
            pick = i;
            found = 1'b1;
         end
      end
      if (found) begin
         if (w.req_type == ACC_WRITE)
            line_dirty[base + pick] = 1'b1;
         promote_way(base, nways, pick);
         r.hit = 1'b1;
         r.way = pick[2:0];
         return r;
      end
      // Miss: an empty way is filled first, and nothing is reported as evicted.
      for (int unsigned i = 0; i < nways && !found; i++) begin
         if (!line_valid[base + i]) begin
            pick = i;
            found = 1'b1;
         end
      end
      // Otherwise the oldest way goes; on equal ranks the lowest way number.
      if (!found) begin
         best = 0;
         for (int unsigned i = 0; i < nways; i++) begin
            if (i == 0 || line_rank[base + i] > best) begin
               best = line_rank[base + i];
               pick = i;
            end
         end
         r.victim_valid = 1'b1;
         r.victim_dirty = line_dirty[base + pick];
         r.victim_tag = line_tag[base + pick];
      end
      line_valid[base + pick] = 1'b1;
      line_dirty[base + pick] = (w.req_type == ACC_WRITE);
      line_tag[base + pick] = tag;
      promote_way(base, nways, pick);
      r.way = pick[2:0];
      return r;
   endfunction

   // Build a byte address from tag, set and offset under the current split.
   function automatic logic [31:0] block_address(logic [31:0] tag, int unsigned set_no,
                                                 logic [31:0] offset);
      int unsigned sb;
      sb = eff_set_bits();
      return (tag << (cfg_offset_bits + sb))
             | ((set_no & ((32'd1 << sb) - 1)) << cfg_offset_bits)
             | (offset & ((32'd1 << cfg_offset_bits) - 1));
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one access word and hold it until the block takes it. The expected
   // result is computed at the accepting edge, so it sees every earlier access.
   task automatic send_access(logic kind, logic [31:0] addr);
      req_word_type w;
      int unsigned gap;
      w.req_type = kind;
      w.address = addr;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      pending_lookups.push_back(cache_lookup(w));
      if (pace_on) begin
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // About a quarter of the bursts run straight into the next one.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Stop offering words and wait until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
   endtask

   // Register write: setup phase, then access phase until pready.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_OFFSET_BITS: cfg_offset_bits = 32'(value[2:0]);
         REG_SET_BITS: cfg_set_bits = 32'(value[3:0]);
         REG_WAYS_IN_USE: cfg_ways = 32'(value[3:0]);
         default: ;
      endcase
   endtask

   // Register read, compared against the value the bench last wrote. The
   // register keeps the raw value; clamping only happens when it is used.
   task automatic csr_check(logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_OFFSET_BITS: want = cfg_offset_bits;
         REG_SET_BITS: want = cfg_set_bits;
         default: want = cfg_ways;
      endcase
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      check_field("register readback", want, prdata);
   endtask

   // Registers only change while the block has nothing in flight.
   task automatic set_config(int unsigned ob, int unsigned sb, int unsigned ways);
      drain_results();
      csr_write(REG_OFFSET_BITS, ob);
      csr_write(REG_SET_BITS, sb);
      csr_write(REG_WAYS_IN_USE, ways);
      csr_check(REG_OFFSET_BITS);
      csr_check(REG_SET_BITS);
      csr_check(REG_WAYS_IN_USE);
   endtask

   // All-ones data into every register, including the index past the end,
   // which the block must ignore.
   task automatic test_register_access();
      csr_write(REG_OFFSET_BITS, 32'hFFFF_FFFF);
      csr_write(REG_SET_BITS, 32'hFFFF_FFFF);
      csr_write(REG_WAYS_IN_USE, 32'hFFFF_FFFF);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      csr_check(REG_OFFSET_BITS);
      csr_check(REG_SET_BITS);
      csr_check(REG_WAYS_IN_USE);
      set_config(0, 0, 0);
   endtask

   // Cold fills, write hits, LRU eviction of clean and dirty blocks, and the
   // lowest and highest addresses, all with the reset configuration.
   task automatic test_fill_and_hit();
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 32'(RST_WAYS_IN_USE));
      send_access(ACC_READ, block_address(32'h1, 0, 0));
      send_access(ACC_WRITE, block_address(32'h1, 0, 31));
      send_access(ACC_READ, block_address(32'h2, 0, 4));
      send_access(ACC_READ, block_address(32'h3, 0, 8));
      send_access(ACC_WRITE, block_address(32'h4, 0, 12));
      // Touch way 0 again so that way 1 is the oldest when the set overflows.
      send_access(ACC_READ, block_address(32'h1, 0, 0));
      send_access(ACC_READ, block_address(32'h5, 0, 0));
      send_access(ACC_READ, block_address(32'h2, 0, 0));
      send_access(ACC_WRITE, block_address(32'h6, 0, 0));
      send_access(ACC_READ, block_address(32'h7, 0, 0));
      send_access(ACC_READ, 32'h0000_0000);
      send_access(ACC_WRITE, 32'hFFFF_FFFF);
      send_access(ACC_READ, 32'hFFFF_FFE0);
      send_access(ACC_WRITE, 32'hFFFF_FFFF);
   endtask

   // Shrinking the way count lets a second copy of a tag land in way 0 while
   // the first sits in way 1; widening it again must hit the lower way.
   task automatic test_duplicate_tags();
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 1);
      send_access(ACC_READ, block_address(32'h11, 3, 0));
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 2);
      send_access(ACC_WRITE, block_address(32'h22, 3, 0));
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 1);
      send_access(ACC_READ, block_address(32'h22, 3, 0));
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 2);
      send_access(ACC_READ, block_address(32'h22, 3, 0));
      send_access(ACC_WRITE, block_address(32'h22, 3, 0));
   endtask

   // The receiver holds off for a long stretch while words keep coming with no
   // gaps, so the block must stall its input; then the sender waits for all results.
   task automatic test_backpressure();
      logic [31:0] tags [3];
      set_config(32'(RST_OFFSET_BITS), 32'(RST_SET_BITS), 32'(RST_WAYS_IN_USE));
      for (int i = 0; i < 3; i++)
         tags[i] = $urandom;
      pace_on = 1'b0;
      hold_request = LONG_HOLD;
      for (int n = 0; n < 40; n++)
         send_access(1'($urandom_range(0, 1)), block_address(tags[n % 3], 7, $urandom));
      pace_on = 1'b1;
      drain_results();
   endtask

   // One random phase under one setting. Most words draw their tag from a pool a
   // little larger than the way count and their set from a narrow window, so the
   // sets see hits, refills and evictions; the rest are fully random addresses.
   task automatic test_random_phase(int unsigned p);
      logic [31:0] tag_pool [12];
      int unsigned ob, sb, ways, pool_size, win, base_set;
      logic [31:0] addr;
      case (p)
         0: begin ob = 5; sb = 8; ways = 4; end
         1: begin ob = 0; sb = 0; ways = 1; end
         2: begin ob = 7; sb = 8; ways = 8; end
         3: begin ob = 7; sb = 15; ways = 15; end
         4: begin ob = 0; sb = 4; ways = 0; end
         5: begin ob = 3; sb = 2; ways = 2; end
         6: begin ob = 1; sb = 1; ways = 3; end
         7: begin ob = 6; sb = 9; ways = 9; end
         8: begin ob = 2; sb = 7; ways = 5; end
         9: begin ob = 4; sb = 3; ways = 6; end
         10: begin ob = 0; sb = 8; ways = 8; end
         default: begin ob = 7; sb = 0; ways = 7; end
      endcase
      set_config(ob, sb, ways);
      pool_size = eff_ways() + $urandom_range(1, 4);
      for (int i = 0; i < pool_size; i++)
         tag_pool[i] = $urandom;
      win = 1;
      base_set = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         if (n % 40 == 0) begin
            win = $urandom_range(1, 3);
            base_set = $urandom;
         end
         if ($urandom_range(0, 99) < 85)
            addr = block_address(tag_pool[$urandom_range(0, pool_size - 1)],
                                 base_set + $urandom_range(0, win - 1), $urandom);
         else
            addr = $urandom;
         send_access(1'($urandom_range(0, 1)), addr);
      end
   endtask

   // Result checker: every accepted result word must match the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t ns: result word with none expected, got %p", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = pending_lookups.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_word.hit));
            check_field("way", 32'(want.way), 32'(rsp_word.way));
            check_field("set_sel", 32'(want.set_sel), 32'(rsp_word.set_sel));
            check_field("victim_valid", 32'(want.victim_valid),
                        32'(rsp_word.victim_valid));
            check_field("victim_dirty", 32'(want.victim_dirty),
                        32'(rsp_word.victim_dirty));
            check_field("victim_tag", want.victim_tag, rsp_word.victim_tag);
         end
      end
   end

   // Receiver: a long hold when the pressure test asks for one, otherwise one of
   // four stall patterns drawn at random, including full-rate stretches.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      stall_tick++;
      if (stall_tick % 64 == 0)
         stall_mode = rx_pattern_type'($urandom_range(0, 3));
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_STREAM: rsp_ready <= 1'b1;
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= (stall_tick % 5) >= 2;
         endcase
      end
   end

   // Watchdog: the run is stuck if no word, result or register access completes
   // before idle_cycles reaches IDLE_LIMIT. That covers the clearing pass and the long hold.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("set_assoc_lru_cache_tags regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // The tag store comes out of reset empty, with ranks equal to way numbers.
      for (int i = 0; i < ENTRIES; i++) begin
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i] = '0;
         line_rank[i] = i % N_WAYS;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // The block clears its set rows after reset; wait until it takes words.
      do @(posedge clock); while (!req_ready);
      test_register_access();
      test_fill_and_hit();
      test_duplicate_tags();
      test_backpressure();
      for (int p = 0; p < PHASES; p++)
         test_random_phase(p);
      drain_results();
      // Keep the clock running so that a stray extra result would still be caught.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("set_assoc_lru_cache_tags regression: pass");
      else
         $display("set_assoc_lru_cache_tags regression: fail");
      $finish;
   end

endmodule
